// ===== rtl/trilinear_prolongation_3d_core_assert.svh =====
// Assertion macros used by the back part of the trilinear prolongation RTL.
`ifndef TRILINEAR_PROLONGATION_3D_CORE_ASSERT_SVH
`define TRILINEAR_PROLONGATION_3D_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TP3_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TP3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tp3_pkg.sv =====
// Shared types, constants and helper functions for the trilinear prolongation core.
package tp3_pkg;

    localparam int MAX_DIM     = 64;
    localparam int DIM_BITS    = $clog2(MAX_DIM);
    localparam int SIZE_BITS   = 7;
    localparam int FINE_BITS   = 7;
    localparam int SAMPLE_BITS = 32;
    localparam int SLOTS       = 3;
    localparam int SLOT_BITS   = 2;
    localparam int RAM_DEPTH   = SLOTS * MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS   = $clog2(RAM_DEPTH);
    localparam int TAPS        = 8;
    localparam int TAP_BITS    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int ACC_BITS    = SAMPLE_BITS + 8;
    localparam int ROUND_SHIFT = 6;

    localparam logic [TAP_BITS-1:0] TAP_LAST  = TAP_BITS'(TAPS - 1);
    localparam logic [TAP_BITS-1:0] FINE_LAST = TAP_BITS'(TAPS - 1);

    // weights over 64
    localparam logic signed [ACC_BITS-1:0] W_CENTER = ACC_BITS'(27);
    localparam logic signed [ACC_BITS-1:0] W_FACE   = ACC_BITS'(9);
    localparam logic signed [ACC_BITS-1:0] W_EDGE   = ACC_BITS'(3);
    localparam logic signed [ACC_BITS-1:0] W_CORNER = ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(32);

    localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(MAX_DIM);
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(64);

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                 emit;
        logic                 last_sample;
        logic [FINE_BITS-1:0] base_x;
        logic [FINE_BITS-1:0] base_y;
        logic [FINE_BITS-1:0] base_z;
    } cell_meta_t;

    typedef struct packed {
        sample_t              sample;
        logic [SLOT_BITS-1:0] slot;
        logic [DIM_BITS-1:0]  row;
        logic [DIM_BITS-1:0]  col;
        cell_meta_t           meta;
    } item_t;

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        r = v;
        if (v < SIZE_MIN)
        begin
            r = SIZE_MIN;
        end
        else if (v > SIZE_MAX)
        begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

    // tap t -> {x back, y back}: the eight neighbors other than (0,0)
    function automatic logic [3:0] tap_ab(input logic [TAP_BITS-1:0] t);
        logic [3:0] r;
        unique case (t)
            3'd0: r = {2'd0, 2'd1};
            3'd1: r = {2'd0, 2'd2};
            3'd2: r = {2'd1, 2'd0};
            3'd3: r = {2'd1, 2'd1};
            3'd4: r = {2'd1, 2'd2};
            3'd5: r = {2'd2, 2'd0};
            3'd6: r = {2'd2, 2'd1};
            3'd7: r = {2'd2, 2'd2};
        endcase
        return r;
    endfunction

    // (slot - back) mod 3
    function automatic logic [SLOT_BITS-1:0] slot_back(input logic [SLOT_BITS-1:0] slot,
                                                      input logic [1:0] back);
        logic [2:0] s;
        s = {1'b0, slot} + 3'd3 - {1'b0, back};
        if (s >= 3'd3)
        begin
            s = s - 3'd3;
        end
        return s[SLOT_BITS-1:0];
    endfunction

    function automatic logic signed [ACC_BITS-1:0] ext(input sample_t v);
        return $signed({{(ACC_BITS-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v});
    endfunction

endpackage

// ===== rtl/tp3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tp3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tp3_queue.sv =====
// Two-entry queue between the front and the back part.
module tp3_queue import tp3_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  head_valid
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full       = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/tp3_front.sv =====
// Front part: register port, raster position, plane store write, item classification.
module tp3_front import tp3_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              coarse_sample,
    input  logic                 reads_idle,
    input  logic                 q_full,
    output logic                 push,
    output item_t                push_item,
    output logic                 ram_we,
    output logic [ADDR_BITS-1:0] ram_waddr
);

    logic [SIZE_BITS-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [DIM_BITS-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [DIM_BITS-1:0]  pos_x_next, pos_y_next, pos_z_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [SIZE_BITS-1:0] sx, sy, sz;
    logic [SIZE_BITS-1:0] z_inc, y_inc, x_inc;
    logic                 cfg_we, restart, at_origin, accept;

    assign sx = clamp_size(size_x_reg);
    assign sy = clamp_size(size_y_reg);
    assign sz = clamp_size(size_z_reg);

    assign cfg_we  = psel && penable && pwrite;
    assign restart = cfg_we && (paddr[3:2] == REG_SIZE_X || paddr[3:2] == REG_SIZE_Y ||
                                paddr[3:2] == REG_SIZE_Z);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SIZE_X: prdata = {25'd0, size_x_reg};
            REG_SIZE_Y: prdata = {25'd0, size_y_reg};
            REG_SIZE_Z: prdata = {25'd0, size_z_reg};
            default:    prdata = '0;
        endcase
    end

    // a new grid waits until all reads of the previous one are issued
    assign at_origin    = (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0);
    assign sample_stall = q_full || (at_origin && !reads_idle);
    assign accept       = sample_valid && !sample_stall;

    assign push      = accept;
    assign ram_we    = accept;
    assign ram_waddr = {slot_reg, pos_y_reg, pos_z_reg};

    always_comb
    begin
        push_item.sample           = coarse_sample;
        push_item.slot             = slot_reg;
        push_item.row              = pos_y_reg;
        push_item.col              = pos_z_reg;
        push_item.meta.emit        = (pos_x_reg >= DIM_BITS'(2)) && (pos_y_reg >= DIM_BITS'(2))
                                     && (pos_z_reg >= DIM_BITS'(2));
        push_item.meta.last_sample = ({1'b0, pos_x_reg} == sx - 1'b1)
                                     && ({1'b0, pos_y_reg} == sy - 1'b1)
                                     && ({1'b0, pos_z_reg} == sz - 1'b1);
        push_item.meta.base_x      = FINE_BITS'({pos_x_reg, 1'b0}) - FINE_BITS'(3);
        push_item.meta.base_y      = FINE_BITS'({pos_y_reg, 1'b0}) - FINE_BITS'(3);
        push_item.meta.base_z      = FINE_BITS'({pos_z_reg, 1'b0}) - FINE_BITS'(3);
    end

    always_comb
    begin
        z_inc      = {1'b0, pos_z_reg} + 1'b1;
        y_inc      = {1'b0, pos_y_reg} + 1'b1;
        x_inc      = {1'b0, pos_x_reg} + 1'b1;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = z_inc[DIM_BITS-1:0];
        slot_next  = slot_reg;
        if (z_inc >= sz)
        begin
            pos_z_next = '0;
            pos_y_next = y_inc[DIM_BITS-1:0];
            if (y_inc >= sy)
            begin
                pos_y_next = '0;
                pos_x_next = x_inc[DIM_BITS-1:0];
                slot_next  = (slot_reg == SLOT_BITS'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                if (x_inc >= sx)
                begin
                    pos_x_next = '0;
                    slot_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            slot_reg   <= '0;
        end
        else if (restart)
        begin
            unique case (paddr[3:2])
                REG_SIZE_X: size_x_reg <= pwdata[SIZE_BITS-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[SIZE_BITS-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[SIZE_BITS-1:0];
                default:    size_x_reg <= size_x_reg;
            endcase
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            slot_reg  <= '0;
        end
        else if (accept)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ===== rtl/tp3_back.sv =====
// Back part: neighbor reads, 3x3x3 window, weighted sums and result register.
module tp3_back import tp3_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  item_t                  q_head,
    output logic                   q_pop,
    output logic                   ram_re,
    output logic [ADDR_BITS-1:0]   ram_raddr,
    input  sample_t                ram_rdata,
    output logic                   reads_idle,
    output logic                   fine_valid,
    input  logic                   fine_stall,
    output sample_t                fine_value,
    output logic [FINE_BITS-1:0]   fine_x,
    output logic [FINE_BITS-1:0]   fine_y,
    output logic [FINE_BITS-1:0]   fine_z,
    output logic                   last_of_cell,
    output logic                   grid_done
);

    `include "trilinear_prolongation_3d_core_assert.svh"

    // read issue / capture
    logic [TAP_BITS-1:0]   tap_reg;
    logic                  cap_v_reg, cap_last_reg;
    logic [TAP_BITS-1:0]   cap_t_reg;
    item_t                 cap_item_reg;
    sample_t               asm_reg [TAPS-1];
    // assembled column and window [z back][x back][y back]
    sample_t               col_reg [3][3];
    cell_meta_t            col_meta_reg;
    logic                  col_full_reg;
    sample_t               win_reg [3][3][3];
    // emitter
    logic                  em_run_reg;
    logic [TAP_BITS-1:0]   em_n_reg;
    cell_meta_t            em_meta_reg;
    // partial sums stage
    logic                  p_v_reg;
    logic signed [ACC_BITS-1:0] p_part_reg [4];
    logic [FINE_BITS-1:0]  p_x_reg, p_y_reg, p_z_reg;
    logic                  p_last_reg, p_done_reg;
    // result stage
    logic                  o_v_reg;
    sample_t               o_value_reg;
    logic [FINE_BITS-1:0]  o_x_reg, o_y_reg, o_z_reg;
    logic                  o_last_reg, o_done_reg;

    logic o_load, p_adv, em_issue, em_last, shift_now, col_free, hold, issue, col_load;
    logic [3:0] rd_ab;
    logic [1:0] na, nb, nc;
    logic signed [ACC_BITS-1:0] acc;
    sample_t vc, vx, vy, vz, vxy, vxz, vyz, vxyz;

    assign o_load    = !o_v_reg || !fine_stall;
    assign p_adv     = !p_v_reg || o_load;
    assign em_issue  = em_run_reg && p_adv;
    assign em_last   = em_issue && (em_n_reg == FINE_LAST);
    assign shift_now = col_full_reg && (!em_run_reg || em_last);
    assign col_free  = !col_full_reg || shift_now;
    // last read data waits in the RAM output until the column is free
    assign hold      = cap_v_reg && cap_last_reg && !col_free;
    assign issue     = q_valid && !hold;
    assign col_load  = cap_v_reg && cap_last_reg && col_free;

    assign q_pop      = issue && (tap_reg == TAP_LAST);
    assign reads_idle = !q_valid && !cap_v_reg;

    assign rd_ab     = tap_ab(tap_reg);
    assign ram_re    = issue;
    assign ram_raddr = {slot_back(q_head.slot, rd_ab[3:2]),
                        q_head.row - DIM_BITS'(rd_ab[1:0]), q_head.col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg      <= '0;
            cap_v_reg    <= 1'b0;
            cap_last_reg <= 1'b0;
            cap_t_reg    <= '0;
            col_full_reg <= 1'b0;
            em_run_reg   <= 1'b0;
            em_n_reg     <= '0;
            p_v_reg      <= 1'b0;
            o_v_reg      <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (!hold)
            begin
                cap_v_reg    <= issue;
                cap_t_reg    <= tap_reg;
                cap_last_reg <= (tap_reg == TAP_LAST);
            end
            if (col_load)
            begin
                col_full_reg <= 1'b1;
            end
            else if (shift_now)
            begin
                col_full_reg <= 1'b0;
            end
            if (shift_now)
            begin
                em_run_reg <= col_meta_reg.emit;
                em_n_reg   <= '0;
            end
            else if (em_issue)
            begin
                em_n_reg <= em_n_reg + 1'b1;
                if (em_n_reg == FINE_LAST)
                begin
                    em_run_reg <= 1'b0;
                end
            end
            if (p_adv)
            begin
                p_v_reg <= em_issue;
            end
            if (o_load)
            begin
                o_v_reg <= p_v_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cap_item_reg <= q_head;
        end
        if (cap_v_reg && !cap_last_reg)
        begin
            asm_reg[cap_t_reg] <= ram_rdata;
        end
        if (col_load)
        begin
            // taps land at their {x back, y back} place, see tap_ab
            col_reg[0][0] <= cap_item_reg.sample;
            col_reg[0][1] <= asm_reg[0];
            col_reg[0][2] <= asm_reg[1];
            col_reg[1][0] <= asm_reg[2];
            col_reg[1][1] <= asm_reg[3];
            col_reg[1][2] <= asm_reg[4];
            col_reg[2][0] <= asm_reg[5];
            col_reg[2][1] <= asm_reg[6];
            col_reg[2][2] <= ram_rdata;
            col_meta_reg  <= cap_item_reg.meta;
        end
        if (shift_now)
        begin
            win_reg[2]  <= win_reg[1];
            win_reg[1]  <= win_reg[0];
            win_reg[0]  <= col_reg;
            em_meta_reg <= col_meta_reg;
        end
        if (em_issue)
        begin
            p_part_reg[0] <= ext(vc)  * W_CENTER + ext(vx)   * W_FACE;
            p_part_reg[1] <= ext(vy)  * W_FACE   + ext(vxy)  * W_EDGE;
            p_part_reg[2] <= ext(vz)  * W_FACE   + ext(vxz)  * W_EDGE;
            p_part_reg[3] <= ext(vyz) * W_EDGE   + ext(vxyz) * W_CORNER;
            p_x_reg       <= em_meta_reg.base_x + FINE_BITS'(em_n_reg[2]);
            p_y_reg       <= em_meta_reg.base_y + FINE_BITS'(em_n_reg[1]);
            p_z_reg       <= em_meta_reg.base_z + FINE_BITS'(em_n_reg[0]);
            p_last_reg    <= (em_n_reg == FINE_LAST);
            p_done_reg    <= (em_n_reg == FINE_LAST) && em_meta_reg.last_sample;
        end
        if (o_load && p_v_reg)
        begin
            o_value_reg <= acc[ROUND_SHIFT +: SAMPLE_BITS];
            o_x_reg     <= p_x_reg;
            o_y_reg     <= p_y_reg;
            o_z_reg     <= p_z_reg;
            o_last_reg  <= p_last_reg;
            o_done_reg  <= p_done_reg;
        end
    end

    // neighbor index: offset 1 -> forward (back 0), offset 0 -> behind (back 2); center back 1
    always_comb
    begin
        na   = em_n_reg[2] ? 2'd0 : 2'd2;
        nb   = em_n_reg[1] ? 2'd0 : 2'd2;
        nc   = em_n_reg[0] ? 2'd0 : 2'd2;
        vc   = win_reg[1][1][1];
        vx   = win_reg[1][na][1];
        vy   = win_reg[1][1][nb];
        vz   = win_reg[nc][1][1];
        vxy  = win_reg[1][na][nb];
        vxz  = win_reg[nc][na][1];
        vyz  = win_reg[nc][1][nb];
        vxyz = win_reg[nc][na][nb];
    end

    assign acc = p_part_reg[0] + p_part_reg[1] + p_part_reg[2] + p_part_reg[3] + ROUND_HALF;

    assign fine_valid   = o_v_reg;
    assign fine_value   = o_value_reg;
    assign fine_x       = o_x_reg;
    assign fine_y       = o_y_reg;
    assign fine_z       = o_z_reg;
    assign last_of_cell = o_last_reg;
    assign grid_done    = o_done_reg;

    `TP3_ASSERT_NEXT(a_taps_back_to_back, cap_v_reg && !cap_last_reg, cap_v_reg, "read taps of one item not contiguous")
    `TP3_ASSERT_NEXT(a_col_kept, col_full_reg && !shift_now, col_full_reg, "assembled column lost")
    `TP3_ASSERT_SAME(a_no_shift_mid_cell, shift_now && em_run_reg, em_last, "window shifted during a cell")
    `TP3_ASSERT_SAME(a_done_on_last, fine_valid && grid_done, last_of_cell, "grid end not on cell end")

endmodule

// ===== rtl/trilinear_prolongation_3d_core.sv =====
// Top level of the 3D trilinear prolongation core.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  sample    | sample_valid / sample_stall  | coarse_sample
//  fine      | fine_valid / fine_stall      | fine_value, fine_x/y/z, last_of_cell,
//            |                              | grid_done
//  config    | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
// In the back part, the eight in-plane neighbors of each coarse sample are read
// from the plane store through its single read port, one per cycle unless the column
// is still busy, while the eight fine values of the previous cell leave the result
// register, one per cycle while fine_stall is low.
// Reset clears position, sizes (64) and all valid flags; the plane store is not cleared.
// The front takes a new sample while the back works and the queue has room; the
// first sample of a new grid waits until the previous grid's reads are all issued.
// A stalled result holds its value; stalls back up through the window into the queue.
module trilinear_prolongation_3d_core import tp3_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              coarse_sample,
    output logic                 fine_valid,
    input  logic                 fine_stall,
    output sample_t              fine_value,
    output logic [FINE_BITS-1:0] fine_x,
    output logic [FINE_BITS-1:0] fine_y,
    output logic [FINE_BITS-1:0] fine_z,
    output logic                 last_of_cell,
    output logic                 grid_done
);

    logic                 push, q_full, q_pop, q_valid, reads_idle;
    item_t                push_item, q_head;
    logic                 ram_we, ram_re;
    logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
    sample_t              ram_rdata;

    assign pready = 1'b1;

    // front: register port, raster position, store write, classification
    tp3_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .coarse_sample (coarse_sample),
        .reads_idle    (reads_idle),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr)
    );

    // decouples the sample transfer from the eight-read neighbor sequence
    tp3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    // plane store: three x-planes, slot/row/column addressing
    tp3_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_plane_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_item.sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: neighbor reads, window, weighted sums, result register
    tp3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .reads_idle   (reads_idle),
        .fine_valid   (fine_valid),
        .fine_stall   (fine_stall),
        .fine_value   (fine_value),
        .fine_x       (fine_x),
        .fine_y       (fine_y),
        .fine_z       (fine_z),
        .last_of_cell (last_of_cell),
        .grid_done    (grid_done)
    );

endmodule
